@@ sv/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, checked outside of reset.
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication, checked outside of reset.
`define ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

@@ sv/thee_pkg.sv @@
`default_nettype none
package thee_pkg;
   localparam int HEAP_CAPACITY = 32;
   localparam int TICK_PERIOD   = 65536;
   localparam int MAX_RESULTS   = 32;
   localparam int ID_W          = 6;
   localparam int DL_W          = 16;
   localparam int SLOT_W        = $clog2(HEAP_CAPACITY);
   localparam int POS_W         = SLOT_W + 1;
   localparam int ADDR_W        = SLOT_W + 1;
   localparam int NUM_W         = $clog2(MAX_RESULTS + 1);

   typedef struct packed {
      logic [DL_W-1:0] deadline;
      logic [ID_W-1:0] id;
   } entry_type;

   typedef struct packed {
      logic            mode;
      logic [ID_W-1:0] timer_id;
      logic [15:0]     delay;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0] expired_id;
      logic            last;
   } rsp_type;

   localparam logic MODE_START = 1'b0;
   localparam logic MODE_TICK  = 1'b1;

   // Memory address of a 1-based heap position within the selected heap.
   function automatic logic [ADDR_W-1:0] slot_addr(logic sel, logic [POS_W:0] pos);
      logic [POS_W:0] z;
      z = pos - 1'b1;
      return {sel, z[SLOT_W-1:0]};
   endfunction
endpackage
`default_nettype wire

@@ sv/thee_ram.sv @@
`default_nettype none
module thee_ram (
   input  wire logic                         clock,
   input  wire logic                         wr_en,
   input  wire logic [thee_pkg::ADDR_W-1:0]  wr_addr,
   input  wire thee_pkg::entry_type          wr_data,
   input  wire logic [thee_pkg::ADDR_W-1:0]  rd_addr,
   output thee_pkg::entry_type               rd_data
);
   thee_pkg::entry_type mem [2**thee_pkg::ADDR_W];
   thee_pkg::entry_type rd_data_ff;

   // Both heaps share this array; read data is registered.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

@@ sv/timer_heap_expiry_engine.sv @@
`default_nettype none
// Timer queue built from two binary min-heaps held in one shared memory.
// Input channel: an item is taken when start is high and busy is low.
// mode 0 starts a timer (deadline = counter + delay, delay 0 is ignored),
// mode 1 advances the tick counter and reports expired timers.
// Result channel: rsp_valid marks one expired id for one cycle; rsp_item.last
// is set on the final expiry of a tick. The receiver cannot stall, so every
// result is simply presented once.
// A start with delay 0 or into a full target heap is dropped while busy stays low.
// Other starts sift the new entry up, reading the parent and comparing at each
// level (at most 5 levels here). A tick reads and checks the heap top; per
// expired timer it moves the last entry to the top and sifts it down, each
// level reading both children, selecting the earlier one and comparing it.
// The speed is set by the single memory read port and the one shared
// deadline comparator, which serve one heap step at a time.
// A result is registered, appearing in the cycle after the check that decides it.
// Reset clears the counts, the tick counter and the heap selection; the
// heap memory needs no clearing since data read from unfilled slots is never used.
module timer_heap_expiry_engine (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire thee_pkg::req_type req_item,
   output logic                   rsp_valid,
   output thee_pkg::rsp_type      rsp_item
);
   localparam logic [thee_pkg::DL_W:0]   PERIOD17  = (thee_pkg::DL_W+1)'(thee_pkg::TICK_PERIOD);
   localparam logic [thee_pkg::DL_W-1:0] TICK_LAST = thee_pkg::DL_W'(thee_pkg::TICK_PERIOD - 1);
   localparam logic [thee_pkg::POS_W-1:0] CAP     = thee_pkg::POS_W'(thee_pkg::HEAP_CAPACITY);
   localparam logic [thee_pkg::NUM_W-1:0] MAXN    = thee_pkg::NUM_W'(thee_pkg::MAX_RESULTS);

   typedef enum logic [3:0] {
      ST_IDLE, ST_UP_RD, ST_UP_CMP, ST_CHK_RD, ST_CHK, ST_POP_RD, ST_POP_LD,
      ST_SD_RDL, ST_SD_RDR, ST_SD_SEL, ST_SD_DEC
   } state_type;

   state_type                     state_ff;
   logic                          hsel_ff;
   logic                          cur2_ff;
   logic [thee_pkg::POS_W-1:0]    cnt_ff [2];
   logic [thee_pkg::DL_W-1:0]     tick_ff;
   logic [thee_pkg::POS_W-1:0]    pos_ff;
   logic [thee_pkg::POS_W-1:0]    cpos_ff;
   thee_pkg::entry_type           cur_e_ff;
   thee_pkg::entry_type           lft_ff;
   thee_pkg::entry_type           chd_ff;
   logic [thee_pkg::NUM_W-1:0]    n_ff;
   logic                          pend_v_ff;
   logic [thee_pkg::ID_W-1:0]     pend_id_ff;
   logic                          rsp_valid_ff;
   thee_pkg::rsp_type             rsp_item_ff;

   logic                          mem_we;
   logic [thee_pkg::ADDR_W-1:0]   mem_wa;
   thee_pkg::entry_type           mem_wd;
   logic [thee_pkg::ADDR_W-1:0]   mem_ra;
   thee_pkg::entry_type           rd_data;

   logic [thee_pkg::DL_W-1:0]     cmp_a;
   logic [thee_pkg::DL_W-1:0]     cmp_b;
   logic                          cmp_lt;

   logic [thee_pkg::POS_W-1:0]    hcnt;
   logic [thee_pkg::POS_W:0]      lpos;
   logic [thee_pkg::POS_W:0]      rpos;
   logic [thee_pkg::POS_W:0]      pos_w;
   logic [thee_pkg::POS_W:0]      hcnt_w;

   logic [thee_pkg::DL_W:0]       sum17;
   logic [thee_pkg::DL_W:0]       wsum17;
   logic                          wrap;
   logic [thee_pkg::DL_W-1:0]     new_dl;
   logic                          tgt;
   logic [thee_pkg::DL_W:0]       tick_inc;
   logic [thee_pkg::DL_W-1:0]     tick_nxt;
   logic                          qualify;

   assign hcnt   = cnt_ff[hsel_ff];
   assign pos_w  = {1'b0, pos_ff};
   assign hcnt_w = {1'b0, hcnt};
   assign lpos   = {pos_ff, 1'b0};
   assign rpos   = {pos_ff, 1'b1};

   // Deadline of a new timer, wrapped into the next epoch when needed.
   always_comb begin
      sum17  = {1'b0, tick_ff} + {1'b0, req_item.delay};
      wrap   = sum17 >= PERIOD17;
      wsum17 = sum17 - PERIOD17;
      if (wsum17 >= PERIOD17) begin
         wsum17 = PERIOD17 - 1'b1;
      end
      new_dl = wrap ? wsum17[thee_pkg::DL_W-1:0] : sum17[thee_pkg::DL_W-1:0];
      tgt    = (wrap && tick_ff != TICK_LAST) ? ~cur2_ff : cur2_ff;
   end

   // Tick counter increment with wrap.
   always_comb begin
      tick_inc = {1'b0, tick_ff} + 1'b1;
      tick_nxt = (tick_inc >= PERIOD17) ? '0 : tick_inc[thee_pkg::DL_W-1:0];
   end

   // The one shared deadline comparator, its operands chosen by the step.
   always_comb begin
      case (state_ff)
         ST_CHK: begin
            cmp_a = tick_ff;
            cmp_b = rd_data.deadline;
         end
         ST_SD_SEL: begin
            cmp_a = rd_data.deadline;
            cmp_b = lft_ff.deadline;
         end
         ST_SD_DEC: begin
            cmp_a = chd_ff.deadline;
            cmp_b = cur_e_ff.deadline;
         end
         default: begin
            cmp_a = cur_e_ff.deadline;
            cmp_b = rd_data.deadline;
         end
      endcase
      cmp_lt = cmp_a < cmp_b;
   end

   assign qualify = (hcnt != '0) && (n_ff < MAXN) && !cmp_lt;

   // Memory port control for each step of the sequencer.
   always_comb begin
      mem_we = 1'b0;
      mem_wa = thee_pkg::slot_addr(hsel_ff, pos_w);
      mem_wd = cur_e_ff;
      mem_ra = thee_pkg::slot_addr(hsel_ff, pos_w);
      case (state_ff)
         ST_UP_RD: begin
            if (pos_ff == 1) begin
               mem_we = 1'b1;
            end else begin
               mem_ra = thee_pkg::slot_addr(hsel_ff, pos_w >> 1);
            end
         end
         ST_UP_CMP: begin
            mem_we = 1'b1;
            mem_wd = cmp_lt ? rd_data : cur_e_ff;
         end
         ST_CHK_RD: begin
            mem_ra = thee_pkg::slot_addr(hsel_ff, (thee_pkg::POS_W+1)'(1));
         end
         ST_POP_RD: begin
            mem_ra = thee_pkg::slot_addr(hsel_ff, hcnt_w);
         end
         ST_SD_RDL: begin
            if (lpos > hcnt_w) begin
               mem_we = 1'b1;
            end else begin
               mem_ra = thee_pkg::slot_addr(hsel_ff, lpos);
            end
         end
         ST_SD_RDR: begin
            mem_ra = thee_pkg::slot_addr(hsel_ff, rpos);
         end
         ST_SD_DEC: begin
            mem_we = 1'b1;
            mem_wd = cmp_lt ? chd_ff : cur_e_ff;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   thee_ram u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wa),
      .wr_data (mem_wd),
      .rd_addr (mem_ra),
      .rd_data (rd_data)
   );

   // Sequencer: state, heap bookkeeping and the result register.
   always_ff @(posedge clock) begin
      rsp_valid_ff <= 1'b0;
      if (reset) begin
         state_ff  <= ST_IDLE;
         hsel_ff   <= 1'b0;
         cur2_ff   <= 1'b0;
         cnt_ff[0] <= '0;
         cnt_ff[1] <= '0;
         tick_ff   <= '0;
         n_ff      <= '0;
         pend_v_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  if (req_item.mode == thee_pkg::MODE_TICK) begin
                     tick_ff   <= tick_nxt;
                     hsel_ff   <= cur2_ff;
                     n_ff      <= '0;
                     pend_v_ff <= 1'b0;
                     state_ff  <= ST_CHK_RD;
                  end else if (req_item.delay != '0 && cnt_ff[tgt] < CAP) begin
                     cnt_ff[tgt] <= cnt_ff[tgt] + 1'b1;
                     pos_ff      <= cnt_ff[tgt] + 1'b1;
                     hsel_ff     <= tgt;
                     cur_e_ff    <= '{deadline: new_dl, id: req_item.timer_id};
                     state_ff    <= ST_UP_RD;
                  end
               end
            end
            ST_UP_RD: begin
               state_ff <= (pos_ff == 1) ? ST_IDLE : ST_UP_CMP;
            end
            ST_UP_CMP: begin
               if (cmp_lt) begin
                  pos_ff   <= pos_ff >> 1;
                  state_ff <= ST_UP_RD;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_CHK_RD: begin
               state_ff <= ST_CHK;
            end
            ST_CHK: begin
               // Hold the newest expiry until it is known whether more follow.
               if (qualify) begin
                  if (pend_v_ff) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_item_ff  <= '{expired_id: pend_id_ff, last: 1'b0};
                  end
                  pend_v_ff  <= 1'b1;
                  pend_id_ff <= rd_data.id;
                  n_ff       <= n_ff + 1'b1;
                  state_ff   <= ST_POP_RD;
               end else begin
                  if (pend_v_ff) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_item_ff  <= '{expired_id: pend_id_ff, last: 1'b1};
                  end
                  if (tick_ff == TICK_LAST && hcnt == '0) begin
                     cur2_ff <= ~cur2_ff;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            ST_POP_RD: begin
               state_ff <= ST_POP_LD;
            end
            ST_POP_LD: begin
               cur_e_ff        <= rd_data;
               cnt_ff[hsel_ff] <= hcnt - 1'b1;
               pos_ff          <= thee_pkg::POS_W'(1);
               state_ff        <= ST_SD_RDL;
            end
            ST_SD_RDL: begin
               state_ff <= (lpos > hcnt_w) ? ST_CHK_RD : ST_SD_RDR;
            end
            ST_SD_RDR: begin
               lft_ff   <= rd_data;
               state_ff <= ST_SD_SEL;
            end
            ST_SD_SEL: begin
               if (rpos <= hcnt_w && cmp_lt) begin
                  chd_ff  <= rd_data;
                  cpos_ff <= rpos[thee_pkg::POS_W-1:0];
               end else begin
                  chd_ff  <= lft_ff;
                  cpos_ff <= lpos[thee_pkg::POS_W-1:0];
               end
               state_ff <= ST_SD_DEC;
            end
            ST_SD_DEC: begin
               if (cmp_lt) begin
                  pos_ff   <= cpos_ff;
                  state_ff <= ST_SD_RDL;
               end else begin
                  state_ff <= ST_CHK_RD;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;
endmodule
`default_nettype wire

@@ sv/thee_checker.sv @@
`default_nettype none
`include "assert_macros.svh"
module thee_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              start,
   input wire logic              busy,
   input wire thee_pkg::req_type req_item,
   input wire logic              rsp_valid
);
   logic acc_tick;
   logic acc_start;

   assign acc_tick  = start && !busy && req_item.mode == thee_pkg::MODE_TICK;
   assign acc_start = start && !busy && req_item.mode == thee_pkg::MODE_START;

   // Results only come out of a tick in progress or right as it ends.
   `ASSERT_IMP(a_rsp_in_tick, clock, reset, rsp_valid, busy || $past(busy))
   // Any accepted transaction is followed by a result-free cycle.
   `ASSERT_NXT(a_no_rsp_after_accept, clock, reset, acc_start || acc_tick, !rsp_valid)
   // A tick always runs at least one heap check.
   `ASSERT_NXT(a_tick_busy, clock, reset, acc_tick, busy)
   // A start with zero delay is dropped at once.
   `ASSERT_NXT(a_zero_delay_idle, clock, reset, acc_start && req_item.delay == '0, !busy)
endmodule

bind timer_heap_expiry_engine thee_checker u_thee_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_item  (req_item),
   .rsp_valid (rsp_valid)
);
`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
`default_nettype none
module testbench;
   import thee_pkg::*;

   localparam int TIMEOUT_CYCLES = 1000000;

   typedef struct {
      logic [DL_W-1:0] deadline;
      logic [ID_W-1:0] id;
   } timer_entry;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_item = '0;
   logic    rsp_valid;
   rsp_type rsp_item;

   // Predictor state: two 1-based heaps, their fill counts, epoch select, tick counter.
   timer_entry heaps[2][HEAP_CAPACITY+1];
   int         heap_count[2];
   int         current_sel;
   int         tick_counter;

   rsp_type expiry_queue[$];
   int      error_count = 0;
   int      cycle_count = 0;

   timer_heap_expiry_engine i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Timeout watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > TIMEOUT_CYCLES) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Compare each expiry transaction with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expiry_queue.size() == 0) begin
            $display("%0t: unexpected expiry id=%0d last=%0b", $time,
                     rsp_item.expired_id, rsp_item.last);
            error_count++;
         end else begin
            rsp_type want;
            want = expiry_queue.pop_front();
            if (want.expired_id !== rsp_item.expired_id)
               begin
               $display("%0t: expired_id expected %0d actual %0d", $time,
                        want.expired_id, rsp_item.expired_id);
               error_count++;
            end
            if (want.last !== rsp_item.last) begin
               $display("%0t: last expected %0b actual %0b", $time,
                        want.last, rsp_item.last);
               error_count++;
            end
         end
      end
   end

   function automatic void swap_entries(int h, int a, int b);
      timer_entry t;
      t = heaps[h][a];
      heaps[h][a] = heaps[h][b];
      heaps[h][b] = t;
   endfunction

   function automatic void heap_push(int h, logic [DL_W-1:0] dl, logic [ID_W-1:0] id);
      int pos;
      if (heap_count[h] >= HEAP_CAPACITY) return;
      heap_count[h]++;
      pos = heap_count[h];
      heaps[h][pos].deadline = dl;
      heaps[h][pos].id = id;
      while (pos > 1 && heaps[h][pos/2].deadline > heaps[h][pos].deadline) begin
         swap_entries(h, pos/2, pos);
         pos = pos / 2;
      end
   endfunction

   function automatic void heap_pop(int h);
      int pos, n, l, r, c;
      heaps[h][1] = heaps[h][heap_count[h]];
      heap_count[h]--;
      n = heap_count[h];
      pos = 1;
      forever begin
         l = pos * 2;
         r = l + 1;
         c = (r <= n && heaps[h][r].deadline < heaps[h][l].deadline) ? r : l;
         if (c <= n && heaps[h][c].deadline < heaps[h][pos].deadline) begin
            swap_entries(h, c, pos);
            pos = c;
         end else break;
      end
   endfunction

   // Predict the expiries caused by one transaction.
   function automatic void predict_timer_step(req_type it);
      int t, n;
      rsp_type r;
      if (it.mode == MODE_START) begin
         if (it.delay == 0) return;
         t = tick_counter + it.delay;
         if (t >= TICK_PERIOD) begin
            t -= TICK_PERIOD;
            if (t >= TICK_PERIOD) t = TICK_PERIOD - 1;
            if (tick_counter == TICK_PERIOD - 1)
               heap_push(current_sel, DL_W'(t), it.timer_id);
            else heap_push(1 - current_sel, DL_W'(t), it.timer_id);
         end else begin
            heap_push(current_sel, DL_W'(t), it.timer_id);
         end
      end else begin
         n = 0;
         tick_counter = (tick_counter + 1) % TICK_PERIOD;
         while (n < MAX_RESULTS && heap_count[current_sel] > 0 &&
                heaps[current_sel][1].deadline <= tick_counter) begin
            r.expired_id = heaps[current_sel][1].id;
            r.last = 1'b0;
            expiry_queue.push_back(r);
            n++;
            heap_pop(current_sel);
         end
         if (n > 0) expiry_queue[$].last = 1'b1;
         if (tick_counter == TICK_PERIOD - 1 && heap_count[current_sel] == 0)
            current_sel = 1 - current_sel;
      end
   endfunction

   // Send one transaction after a random gap, then predict its effect.
   // Called at a falling edge; start stays high into a back-to-back transaction.
   task automatic send_item(logic mode, logic [ID_W-1:0] id, logic [15:0] dly);
      int gap;
      req_type it;
      gap = $urandom_range(0, 10);
      if ($urandom_range(0, 3) == 0) gap = 0;
      it.mode = mode;
      it.timer_id = id;
      it.delay = dly;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_item <= it;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      predict_timer_step(it);
      @(negedge clock);
   endtask

   task automatic send_ticks(int n);
      repeat (n) send_item(MODE_TICK, ID_W'($urandom), 16'($urandom));
   endtask

   // Extremes of the fields, zero delay, duplicate ids, equal deadlines, full heap.
   task automatic test_directed();
      send_item(MODE_START, 6'd0, 16'd0);
      send_item(MODE_START, 6'd63, 16'd1);
      send_item(MODE_START, 6'd5, 16'd2);
      send_item(MODE_START, 6'd5, 16'd2);
      send_item(MODE_START, 6'd42, 16'd2);
      send_item(MODE_START, 6'd21, 16'hFFFF);
      send_ticks(3);
      for (int i = 0; i < HEAP_CAPACITY + 2; i++)
         send_item(MODE_START, i[ID_W-1:0], 16'd3);
      send_ticks(3);
   endtask

   // Random starts with mostly short delays, interleaved with ticks.
   task automatic test_random(int items);
      int k;
      logic [15:0] d;
      for (int i = 0; i < items; i++) begin
         k = $urandom_range(0, 9);
         if (k < 4) begin
            send_item(MODE_TICK, ID_W'($urandom), 16'($urandom));
         end else begin
            if (k == 9) d = 16'($urandom);
            else d = 16'($urandom_range(0, 12));
            send_item(MODE_START, ID_W'($urandom), d);
         end
      end
   endtask

   initial begin
      heap_count[0] = 0;
      heap_count[1] = 0;
      current_sel = 0;
      tick_counter = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(200);
      send_ticks(20);
      start <= 1'b0;
      while (expiry_queue.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (error_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end
endmodule
`default_nettype wire
